// File: design/buzzer_cue_sequencer_defines.svh
// Assertion macros used by the checker of the buzzer cue sequencer.
`ifndef BUZZER_CUE_SEQUENCER_DEFINES_SVH
`define BUZZER_CUE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define BZC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("buzzer cue sequencer check failed");

// Next-cycle implication, disabled while reset is high.
`define BZC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("buzzer cue sequencer check failed");

`endif

// File: design/bzc_pkg.sv
`timescale 1ns / 1ps

package bzc_pkg;

   localparam int STEPS_PER_CUE = 8;
   localparam int STEP_W        = $clog2(STEPS_PER_CUE);
   localparam int FREQ_W        = 15;
   localparam int MS_W          = 9;
   localparam int CUE_W         = 3;
   localparam int PRIO_W        = 3;
   localparam int OP_W          = 2;
   localparam int DUTY_W        = 8;
   localparam int CSR_IDX_W     = 1;

   localparam logic [DUTY_W-1:0] DUTY_ON  = 8'd128;
   localparam logic [DUTY_W-1:0] DUTY_OFF = 8'd0;
   localparam logic [FREQ_W-1:0] RESONANCE_RESET = 15'd4000;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_PLAY    = 2'd1,
      OP_SILENCE = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOUND_ENABLE = 1'b0,
      CSR_RESONANCE    = 1'b1
   } csr_idx_type;

   typedef enum logic [1:0] {
      TONE_OFF = 2'd0,
      TONE_HI  = 2'd1,
      TONE_LO  = 2'd2
   } tone_type;

   typedef struct packed {
      tone_type         tone;
      logic [MS_W-1:0]  ms;
   } step_type;

   typedef struct packed {
      logic              sound_enable;
      logic [FREQ_W-1:0] resonance_hz;
   } cfg_type;

   typedef struct packed {
      logic [FREQ_W-1:0] tone_freq;
      logic [DUTY_W-1:0] drive_duty;
      logic              busy_res;
      logic              request_taken;
   } result_type;

   function automatic step_type mk_step(input tone_type tone, input int ms);
      step_type s;
      s.tone = tone;
      s.ms   = MS_W'(ms);
      return s;
   endfunction

   // Pattern table. Entries past the end marker of a cue read as silence of zero length.
   function automatic step_type cue_step(input logic [CUE_W-1:0] cue,
                                         input logic [STEP_W-1:0] idx);
      step_type s;
      s = mk_step(TONE_OFF, 0);
      case (cue)
         3'd0: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_HI, 90);
               STEP_W'(1): s = mk_step(TONE_OFF, 70);
               STEP_W'(2): s = mk_step(TONE_HI, 90);
               STEP_W'(3): s = mk_step(TONE_OFF, 70);
               STEP_W'(4): s = mk_step(TONE_HI, 90);
               STEP_W'(5): s = mk_step(TONE_OFF, 70);
               STEP_W'(6): s = mk_step(TONE_HI, 220);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd1: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_HI, 110);
               STEP_W'(1): s = mk_step(TONE_OFF, 90);
               STEP_W'(2): s = mk_step(TONE_HI, 110);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd2: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_LO, 120);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd3: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_LO, 70);
               STEP_W'(1): s = mk_step(TONE_OFF, 60);
               STEP_W'(2): s = mk_step(TONE_LO, 70);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd4: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_LO, 300);
               STEP_W'(1): s = mk_step(TONE_OFF, 120);
               STEP_W'(2): s = mk_step(TONE_LO, 300);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd5: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_LO, 80);
               STEP_W'(1): s = mk_step(TONE_HI, 120);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         3'd6: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_HI, 80);
               STEP_W'(1): s = mk_step(TONE_LO, 160);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
         default: begin
            case (idx)
               STEP_W'(0): s = mk_step(TONE_HI, 25);
               default:    s = mk_step(TONE_OFF, 0);
            endcase
         end
      endcase
      return s;
   endfunction

   function automatic logic [PRIO_W-1:0] cue_prio(input logic [CUE_W-1:0] cue);
      logic [PRIO_W-1:0] p;
      case (cue)
         3'd0:    p = 3'd5;
         3'd1:    p = 3'd4;
         3'd2:    p = 3'd3;
         3'd3:    p = 3'd2;
         3'd4:    p = 3'd4;
         3'd5:    p = 3'd1;
         3'd6:    p = 3'd1;
         default: p = 3'd0;
      endcase
      return p;
   endfunction

   // The low tone is three quarters of the resonance, rounded down.
   function automatic logic [FREQ_W-1:0] tone_hz(input tone_type tone,
                                                 input logic [FREQ_W-1:0] res);
      logic [FREQ_W+1:0] triple;
      logic [FREQ_W-1:0] f;
      triple = {2'b00, res} + {1'b0, res, 1'b0};
      case (tone)
         TONE_HI: f = res;
         TONE_LO: f = triple[FREQ_W+1:2];
         default: f = '0;
      endcase
      return f;
   endfunction

endpackage

// File: design/bzc_csr.sv
`timescale 1ns / 1ps

module bzc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bzc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bzc_pkg::FREQ_W-1:0]      csr_wdata,
   output bzc_pkg::cfg_type                cfg
);
   import bzc_pkg::*;

   logic              sound_enable_ff;
   logic              sound_enable_in;
   logic [FREQ_W-1:0] resonance_ff;
   logic [FREQ_W-1:0] resonance_in;

   assign csr_ready = 1'b1;

   always_comb begin
      sound_enable_in = sound_enable_ff;
      resonance_in    = resonance_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SOUND_ENABLE: sound_enable_in = csr_wdata[0];
            CSR_RESONANCE:    resonance_in    = csr_wdata;
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sound_enable_ff <= 1'b1;
         resonance_ff    <= RESONANCE_RESET;
      end else begin
         sound_enable_ff <= sound_enable_in;
         resonance_ff    <= resonance_in;
      end
   end

   assign cfg.sound_enable = sound_enable_ff;
   assign cfg.resonance_hz = resonance_ff;

endmodule

// File: design/bzc_core.sv
`timescale 1ns / 1ps

module bzc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [bzc_pkg::OP_W-1:0]    op,
   input  logic [bzc_pkg::CUE_W-1:0]   cue,
   input  bzc_pkg::cfg_type            cfg,
   output bzc_pkg::result_type         result
);
   import bzc_pkg::*;

   logic              active_ff,   active_in;
   logic [CUE_W-1:0]  cue_ff,      cue_in;
   logic [STEP_W-1:0] step_ff,     step_in;
   logic [MS_W-1:0]   elapsed_ff,  elapsed_in;
   logic [PRIO_W-1:0] prio_ff,     prio_in;
   logic [FREQ_W-1:0] tone_ff,     tone_in;
   logic              taken;

   step_type          cur_step;
   step_type          nxt_step;
   step_type          first_step;
   logic [MS_W-1:0]   elapsed_inc;
   logic [PRIO_W-1:0] new_prio;

   assign cur_step    = cue_step(cue_ff, step_ff);
   assign nxt_step    = cue_step(cue_ff, step_ff + STEP_W'(1));
   assign first_step  = cue_step(cue, '0);
   assign elapsed_inc = elapsed_ff + MS_W'(1);
   assign new_prio    = cue_prio(cue);

   always_comb begin
      active_in  = active_ff;
      cue_in     = cue_ff;
      step_in    = step_ff;
      elapsed_in = elapsed_ff;
      prio_in    = prio_ff;
      tone_in    = tone_ff;
      taken      = 1'b0;
      case (op)
         OP_TICK: begin
            if (active_ff) begin
               if (cur_step.ms == '0) begin
                  active_in = 1'b0;
                  prio_in   = '0;
                  tone_in   = '0;
               end else if (elapsed_inc >= cur_step.ms) begin
                  elapsed_in = '0;
                  if (step_ff == STEP_W'(STEPS_PER_CUE - 1)) begin
                     active_in = 1'b0;
                     prio_in   = '0;
                     tone_in   = '0;
                  end else begin
                     step_in = step_ff + STEP_W'(1);
                     tone_in = tone_hz(nxt_step.tone, cfg.resonance_hz);
                  end
               end else begin
                  elapsed_in = elapsed_inc;
               end
            end
         end
         OP_PLAY: begin
            // A running pattern of strictly higher priority keeps playing.
            if (cfg.sound_enable && !(active_ff && (new_prio < prio_ff))) begin
               active_in  = 1'b1;
               cue_in     = cue;
               prio_in    = new_prio;
               step_in    = '0;
               elapsed_in = '0;
               tone_in    = tone_hz(first_step.tone, cfg.resonance_hz);
               taken      = 1'b1;
            end
         end
         OP_SILENCE: begin
            active_in = 1'b0;
            prio_in   = '0;
            tone_in   = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= 1'b0;
         cue_ff     <= '0;
         step_ff    <= '0;
         elapsed_ff <= '0;
         prio_ff    <= '0;
         tone_ff    <= '0;
      end else if (advance) begin
         active_ff  <= active_in;
         cue_ff     <= cue_in;
         step_ff    <= step_in;
         elapsed_ff <= elapsed_in;
         prio_ff    <= prio_in;
         tone_ff    <= tone_in;
      end
   end

   assign result.tone_freq     = tone_in;
   assign result.drive_duty    = (tone_in != '0) ? DUTY_ON : DUTY_OFF;
   assign result.busy_res      = active_in;
   assign result.request_taken = taken;

endmodule

// File: design/buzzer_cue_sequencer.sv
`timescale 1ns / 1ps
// Buzzer cue sequencer: plays one of eight fixed alert patterns as a tone frequency
// and a PWM duty value.
// Request channel (req_*): one item per command: tick (one millisecond), play a cue,
// or silence. Result channel (rsp_*): exactly one item for every request, giving the
// tone now driven, its duty, whether a pattern is active and whether a play request
// started its pattern.
// After acceptance the item sits in the input register; the state update and pattern
// table lookup then land in the result register, where rsp_valid rises.
// Throughput is one item per cycle; the result register parts the two sides, so a new
// item is taken while a result waits, and req_stall rises only when both the input and
// result registers are full and rsp_stall is high.
// Configuration (csr_*): index 0 enables sound, index 1 sets the resonance in hertz.
// Writes are always ready and take effect at the next play request or step change.
// Reset (synchronous): no pattern active, silent output, sound enabled, 4000 Hz.
// A stalled result holds its value until it is taken.
module buzzer_cue_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bzc_pkg::OP_W-1:0]        req_opcode,
   input  logic [bzc_pkg::CUE_W-1:0]       req_cue_id,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bzc_pkg::FREQ_W-1:0]      rsp_tone_freq,
   output logic [bzc_pkg::DUTY_W-1:0]      rsp_drive_duty,
   output logic                            rsp_busy_res,
   output logic                            rsp_request_taken,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bzc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bzc_pkg::FREQ_W-1:0]      csr_wdata
);
   import bzc_pkg::*;

   cfg_type          cfg;
   result_type       result;
   result_type       rsp_ff;

   logic             in_valid_ff, in_valid_in;
   logic [OP_W-1:0]  in_op_ff;
   logic [CUE_W-1:0] in_cue_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;
   logic             advance;
   logic             accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff  <= req_opcode;
         in_cue_ff <= req_cue_id;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   bzc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bzc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .op      (in_op_ff),
      .cue     (in_cue_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tone_freq     = rsp_ff.tone_freq;
   assign rsp_drive_duty    = rsp_ff.drive_duty;
   assign rsp_busy_res      = rsp_ff.busy_res;
   assign rsp_request_taken = rsp_ff.request_taken;

endmodule

// File: design/bzc_checker.sv
`timescale 1ns / 1ps
`include "buzzer_cue_sequencer_defines.svh"

module bzc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bzc_pkg::FREQ_W-1:0]      rsp_tone_freq,
   input logic [bzc_pkg::DUTY_W-1:0]      rsp_drive_duty,
   input logic                            rsp_busy_res,
   input logic                            rsp_request_taken
);
   import bzc_pkg::*;

   // Duty follows the tone: on while a nonzero frequency is driven, off otherwise.
   `BZC_ASSERT_NOW(a_duty_on, clock, reset, rsp_valid && (rsp_tone_freq != '0), rsp_drive_duty == DUTY_ON)
   `BZC_ASSERT_NOW(a_duty_off, clock, reset, rsp_valid && (rsp_tone_freq == '0), rsp_drive_duty == DUTY_OFF)

   // A request that started its pattern leaves the sequencer busy.
   `BZC_ASSERT_NOW(a_taken_busy, clock, reset, rsp_valid && rsp_request_taken, rsp_busy_res)

   // With no pattern running the buzzer is silent.
   `BZC_ASSERT_NOW(a_idle_silent, clock, reset, rsp_valid && !rsp_busy_res, rsp_tone_freq == '0)

   // A stalled result item stays on the port unchanged.
   `BZC_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_tone_freq) && $stable(rsp_busy_res))

endmodule

bind buzzer_cue_sequencer bzc_checker u_bzc_checker (.*);
